### rtl/ssr_pkg.sv
// Shared types and constants for the servo status packet receiver.
// Used by ssr_parser, ssr_out_reg and servo_status_packet_receiver.
package ssr_pkg;

  // Default sizes
  localparam int FRAME_BYTES_DEF = 16;
  localparam int MAX_PARAMS_DEF  = 8;

  // Frame layout
  localparam logic [7:0] HEADER_BYTE = 8'hFF;
  localparam int HEAD_LEN   = 4;
  localparam int IDX_ID     = 2;
  localparam int IDX_LEN    = 3;
  localparam int IDX_ERR    = 4;
  localparam int IDX_PARAM0 = 5;
  localparam int MIN_LEN    = 2;

  // Register and port widths
  localparam int TIMEOUT_W = 16;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd200;
  localparam logic [TIMEOUT_W-1:0] TICK_MAX      = 16'hFFFF;
  localparam int PARAM_BYTES_W = 64;
  localparam int PARAM_CNT_W   = 4;

  // Input commands
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_SUM = 2'd1,
    ST_TIMEOUT = 2'd2,
    ST_BAD_LEN = 2'd3
  } stat_t;

  // One result item
  typedef struct packed {
    stat_t                    status;
    logic [7:0]               servo_id;
    logic [7:0]               error_byte;
    logic [PARAM_CNT_W-1:0]   param_count;
    logic [PARAM_BYTES_W-1:0] param_bytes;
  } result_t;

endpackage

### rtl/ssr_parser.sv
// Frame parser: header sync, length check, running checksum and parameter capture.
// One item is consumed per accepted cycle. Depends on ssr_pkg.
module ssr_parser import ssr_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int MAX_PARAMS  = MAX_PARAMS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_accept,
  input  logic [1:0]           in_command,
  input  logic [7:0]           in_data_byte,
  input  logic                 cfg_wr_en,
  input  logic [TIMEOUT_W-1:0] cfg_wr_data,
  output logic                 res_valid,
  output result_t              res
);

  localparam int IDX_W  = $clog2(FRAME_BYTES);
  localparam int SLOT_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int PAR_W  = 8 * MAX_PARAMS;
  localparam logic [7:0] LEN_MAX = 8'(FRAME_BYTES - HEAD_LEN);
  localparam logic [7:0] LEN_MIN = 8'(MIN_LEN);
  localparam logic [PARAM_CNT_W-1:0] CNT_MAX = PARAM_CNT_W'(MAX_PARAMS);
  localparam logic [6:0] PARAM_END = 7'(IDX_PARAM0 + MAX_PARAMS);

  logic [TIMEOUT_W-1:0] timeout_r, timeout_nxt;
  logic                 armed_r, armed_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [IDX_W-1:0]     last_idx_r, last_idx_nxt;
  logic                 first_ff_r, first_ff_nxt;
  logic [TIMEOUT_W-1:0] tick_r, tick_nxt;
  logic [7:0]           sum_r, sum_nxt;
  logic [7:0]           id_r, id_nxt;
  logic [7:0]           err_r, err_nxt;
  logic [PARAM_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PAR_W-1:0]     params_r, params_nxt;

  logic [7:0]        len_less2;
  logic [SLOT_W-1:0] slot;
  logic              slot_ok;
  logic              byte_is_ff;

  // Parameter slot for the current byte position
  assign byte_is_ff = (in_data_byte == HEADER_BYTE);
  assign len_less2  = in_data_byte - LEN_MIN;
  assign slot       = SLOT_W'(7'(idx_r) - 7'(IDX_PARAM0));
  assign slot_ok    = (7'(idx_r) < PARAM_END);

  // Next state and result
  always_comb begin
    timeout_nxt  = timeout_r;
    armed_nxt    = armed_r;
    idx_nxt      = idx_r;
    last_idx_nxt = last_idx_r;
    first_ff_nxt = first_ff_r;
    tick_nxt     = tick_r;
    sum_nxt      = sum_r;
    id_nxt       = id_r;
    err_nxt      = err_r;
    cnt_nxt      = cnt_r;
    params_nxt   = params_r;
    res_valid    = 1'b0;
    res          = '0;

    if (cfg_wr_en) begin
      timeout_nxt = cfg_wr_data;
    end

    if (in_accept) begin
      unique case (cmd_t'(in_command))
        CMD_START: begin
          armed_nxt = 1'b1;
          idx_nxt   = '0;
          tick_nxt  = '0;
        end
        CMD_TICK: begin
          if (armed_r) begin
            if (tick_r != TICK_MAX) begin
              tick_nxt = tick_r + 1'b1;
            end
            if (tick_nxt >= timeout_r) begin
              armed_nxt  = 1'b0;
              res_valid  = 1'b1;
              res.status = ST_TIMEOUT;
            end
          end
        end
        CMD_BYTE: begin
          if (armed_r) begin
            priority if (idx_r == '0) begin
              first_ff_nxt = byte_is_ff;
              idx_nxt      = IDX_W'(1);
            end else if (idx_r == IDX_W'(1)) begin
              // slide by one byte unless the header is complete
              if (first_ff_r && byte_is_ff) begin
                idx_nxt = IDX_W'(IDX_ID);
              end else begin
                first_ff_nxt = byte_is_ff;
              end
            end else if (idx_r == IDX_W'(IDX_ID)) begin
              id_nxt     = in_data_byte;
              sum_nxt    = in_data_byte;
              params_nxt = '0;
              idx_nxt    = IDX_W'(IDX_LEN);
            end else if (idx_r == IDX_W'(IDX_LEN)) begin
              // check the length byte at once
              if (in_data_byte < LEN_MIN || in_data_byte > LEN_MAX) begin
                armed_nxt    = 1'b0;
                res_valid    = 1'b1;
                res.status   = ST_BAD_LEN;
                res.servo_id = id_r;
              end else begin
                sum_nxt      = sum_r + in_data_byte;
                last_idx_nxt = IDX_W'(in_data_byte) + IDX_W'(HEAD_LEN - 1);
                cnt_nxt      = (len_less2 < 8'(MAX_PARAMS)) ?
                               PARAM_CNT_W'(len_less2) : CNT_MAX;
                idx_nxt      = IDX_W'(IDX_ERR);
              end
            end else if (idx_r == IDX_W'(IDX_ERR)) begin
              err_nxt = in_data_byte;
              sum_nxt = sum_r + in_data_byte;
              idx_nxt = IDX_W'(IDX_PARAM0);
            end else if (idx_r == last_idx_r) begin
              // checksum byte closes the frame
              armed_nxt       = 1'b0;
              res_valid       = 1'b1;
              res.status      = ((~sum_r) == in_data_byte) ? ST_OK : ST_BAD_SUM;
              res.servo_id    = id_r;
              res.error_byte  = err_r;
              res.param_count = cnt_r;
              res.param_bytes = PARAM_BYTES_W'(params_r);
            end else begin
              sum_nxt = sum_r + in_data_byte;
              if (slot_ok) begin
                params_nxt[8*slot +: 8] = in_data_byte;
              end
              idx_nxt = idx_r + 1'b1;
            end
          end
        end
        CMD_NONE: begin
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= TIMEOUT_RESET;
      armed_r    <= 1'b0;
      idx_r      <= '0;
      last_idx_r <= '0;
      first_ff_r <= 1'b0;
      tick_r     <= '0;
    end else begin
      timeout_r  <= timeout_nxt;
      armed_r    <= armed_nxt;
      idx_r      <= idx_nxt;
      last_idx_r <= last_idx_nxt;
      first_ff_r <= first_ff_nxt;
      tick_r     <= tick_nxt;
    end
  end

  // Frame contents
  always_ff @(posedge clk) begin
    sum_r    <= sum_nxt;
    id_r     <= id_nxt;
    err_r    <= err_nxt;
    cnt_r    <= cnt_nxt;
    params_r <= params_nxt;
  end

  a_res_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> in_accept)
    else $error("result raised without an accepted item");

  a_res_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> !armed_r)
    else $error("receiver still armed after reporting");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && cmd_t'(in_command) == CMD_START) |=>
      (armed_r && idx_r == '0 && tick_r == '0))
    else $error("start did not rearm the receiver");

  a_last_past_err: assert property (@(posedge clk) disable iff (!rst_n)
    (armed_r && idx_r > IDX_W'(IDX_ERR)) |-> (last_idx_r > IDX_W'(IDX_ERR)))
    else $error("checksum position not set before parameter bytes");

endmodule

### rtl/ssr_out_reg.sv
// Result register for the servo status packet receiver.
// Holds one result item and stalls the parser while it is held and out_stall is high. Depends on ssr_pkg.
module ssr_out_reg import ssr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     res_valid,
  input  result_t                  res,
  output logic                     busy,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_status,
  output logic [7:0]               out_servo_id,
  output logic [7:0]               out_error_byte,
  output logic [PARAM_CNT_W-1:0]   out_param_count,
  output logic [PARAM_BYTES_W-1:0] out_param_bytes
);

  logic    valid_r;
  result_t data_r;
  logic    open;

  // Free when empty or being drained this cycle
  assign open = !valid_r || !out_stall;
  assign busy = !open;

  // Load or drop the held item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (open) begin
      valid_r <= res_valid;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk) begin
    if (open && res_valid) begin
      data_r <= res;
    end
  end

  assign out_valid       = valid_r;
  assign out_status      = data_r.status;
  assign out_servo_id    = data_r.servo_id;
  assign out_error_byte  = data_r.error_byte;
  assign out_param_count = data_r.param_count;
  assign out_param_bytes = data_r.param_bytes;

endmodule

### rtl/servo_status_packet_receiver.sv
// Servo status packet receiver, top level. A result item appears on out_valid
// in the cycle after the byte or tick that completes it is accepted.
// Throughput: one input item per cycle; in_stall rises only while a finished
// result is held in the result register and out_stall is high.
// Reset (rst_n, synchronous, active low): receiver idle, timeout register 200.
// Depends on ssr_pkg, ssr_parser and ssr_out_reg.
module servo_status_packet_receiver import ssr_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int MAX_PARAMS  = MAX_PARAMS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_command,
  input  logic [7:0]               in_data_byte,
  input  logic                     cfg_wr_en,
  input  logic [TIMEOUT_W-1:0]     cfg_wr_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_status,
  output logic [7:0]               out_servo_id,
  output logic [7:0]               out_error_byte,
  output logic [PARAM_CNT_W-1:0]   out_param_count,
  output logic [PARAM_BYTES_W-1:0] out_param_bytes
);

  logic    busy;
  logic    in_accept;
  logic    res_valid;
  result_t res;

  // Take an item whenever the result register can absorb its result
  assign in_stall  = busy;
  assign in_accept = in_valid && !busy;

  ssr_parser #(
    .FRAME_BYTES (FRAME_BYTES),
    .MAX_PARAMS  (MAX_PARAMS)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_accept    (in_accept),
    .in_command   (in_command),
    .in_data_byte (in_data_byte),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .res_valid    (res_valid),
    .res          (res)
  );

  ssr_out_reg u_out_reg (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res_valid),
    .res             (res),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_servo_id    (out_servo_id),
    .out_error_byte  (out_error_byte),
    .out_param_count (out_param_count),
    .out_param_bytes (out_param_bytes)
  );

endmodule

### dv/servo_status_packet_receiver_tb.sv
// Self-checking testbench for servo_status_packet_receiver: directed frames, then random
// frames and noise under several timeout settings, checked against an in-bench predictor.
// Depends on ssr_pkg and the receiver RTL.
`timescale 1ns / 100ps

module servo_status_packet_receiver_tb;
  import ssr_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int unsigned RANDOM_ITEMS = 1900;
  localparam int unsigned PHASES       = 6;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One directed row: an item, or a timeout register write
  typedef struct {
    row_kind_t   kind;
    cmd_t        cmd;
    logic [15:0] value;
    bit          typed;
    stat_t       st;
    logic [7:0]  id;
  } dir_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [1:0]               in_command;
  logic [7:0]               in_data_byte;
  logic                     cfg_wr_en;
  logic [TIMEOUT_W-1:0]     cfg_wr_data;
  logic                     out_valid;
  logic                     out_stall;
  logic [1:0]               out_status;
  logic [7:0]               out_servo_id;
  logic [7:0]               out_error_byte;
  logic [PARAM_CNT_W-1:0]   out_param_count;
  logic [PARAM_BYTES_W-1:0] out_param_bytes;

  // Typed expectation riding along with the item on the bus
  bit      row_typed;
  result_t row_report;

  // Predicted receiver state
  logic           rx_armed;
  int unsigned    rx_index;
  logic [7:0]     rx_frame [FRAME_BYTES_DEF];
  int unsigned    rx_frame_len;
  logic [15:0]    rx_ticks;
  logic [15:0]    rx_timeout;

  result_t     awaited_reports [$];
  int unsigned mismatch_count;
  int unsigned items_sent;
  int unsigned reports_seen;
  int unsigned status_seen [4];
  int unsigned cfg_writes;
  bit          quiet;
  int unsigned tick_pct;
  dir_row_t    directed_rows [26];

  servo_status_packet_receiver u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_data_byte    (in_data_byte),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_servo_id    (out_servo_id),
    .out_error_byte  (out_error_byte),
    .out_param_count (out_param_count),
    .out_param_bytes (out_param_bytes)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the predicted receiver by one item; return 1 when it yields a report
  function automatic bit predict_packet(input logic [1:0] cmd, input logic [7:0] b,
                                        output result_t rep);
    int unsigned len;
    int unsigned cnt;
    logic [7:0]  sum;
    bit          hit;
    rep = '0;
    hit = 1'b0;
    case (cmd)
      CMD_START: begin
        rx_armed     = 1'b1;
        rx_index     = 0;
        rx_frame_len = 0;
        rx_ticks     = '0;
      end
      CMD_TICK: begin
        if (rx_armed) begin
          if (rx_ticks != TICK_MAX) rx_ticks++;
          if (rx_ticks >= rx_timeout) begin
            rx_armed   = 1'b0;
            rep.status = ST_TIMEOUT;
            hit        = 1'b1;
          end
        end
      end
      CMD_BYTE: begin
        if (rx_armed && rx_index >= FRAME_BYTES_DEF) begin
          rx_armed = 1'b0;
        end else if (rx_armed) begin
          rx_frame[rx_index] = b;
          rx_index++;
          // slide by one byte when the header is not 0xFF 0xFF
          if (rx_index == 2 && (rx_frame[0] != HEADER_BYTE || rx_frame[1] != HEADER_BYTE)) begin
            rx_frame[0] = rx_frame[1];
            rx_index    = 1;
          end else begin
            if (rx_index == HEAD_LEN) begin
              len = 32'(rx_frame[IDX_LEN]);
              if (len < MIN_LEN || len > FRAME_BYTES_DEF - HEAD_LEN) begin
                rx_armed     = 1'b0;
                rep.status   = ST_BAD_LEN;
                rep.servo_id = rx_frame[IDX_ID];
                hit          = 1'b1;
              end else begin
                rx_frame_len = len + HEAD_LEN;
              end
            end
            // whole frame in: gather parameters and verify the checksum
            if (rx_armed && rx_frame_len != 0 && rx_index >= rx_frame_len) begin
              len = 32'(rx_frame[IDX_LEN]);
              cnt = (len - MIN_LEN < MAX_PARAMS_DEF) ? len - MIN_LEN : MAX_PARAMS_DEF;
              for (int i = 0; i < cnt; i++) rep.param_bytes[8*i +: 8] = rx_frame[IDX_PARAM0 + i];
              sum = '0;
              for (int i = IDX_ID; i + 1 < rx_frame_len; i++) sum += rx_frame[i];
              sum             = ~sum;
              rx_armed        = 1'b0;
              rep.status      = (sum == rx_frame[rx_frame_len - 1]) ? ST_OK : ST_BAD_SUM;
              rep.servo_id    = rx_frame[IDX_ID];
              rep.error_byte  = rx_frame[IDX_ERR];
              rep.param_count = PARAM_CNT_W'(cnt);
              hit             = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return hit;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Track config writes, score results and predict accepted items
  always @(posedge clk) begin : report_check
    result_t want;
    result_t pred;
    bit      hit;
    if (!rst_n) begin
      rx_armed     = 1'b0;
      rx_index     = 0;
      rx_frame_len = 0;
      rx_ticks     = '0;
      rx_timeout   = TIMEOUT_RESET;
      foreach (rx_frame[i]) rx_frame[i] = '0;
    end else begin
      if (cfg_wr_en) rx_timeout = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (awaited_reports.size() == 0) begin
          $error("unexpected report: status %0d id 0x%0h", out_status, out_servo_id);
          mismatch_count++;
        end else begin
          want = awaited_reports.pop_front();
          check_field("status", 64'(want.status), 64'(out_status));
          check_field("servo_id", 64'(want.servo_id), 64'(out_servo_id));
          check_field("error_byte", 64'(want.error_byte), 64'(out_error_byte));
          check_field("param_count", 64'(want.param_count), 64'(out_param_count));
          check_field("param_bytes", want.param_bytes, out_param_bytes);
          reports_seen++;
          status_seen[out_status]++;
        end
      end
      if (in_valid && !in_stall) begin
        hit = predict_packet(in_command, in_data_byte, pred);
        if (row_typed) awaited_reports.push_back(row_report);
        else if (hit) awaited_reports.push_back(pred);
      end
    end
  end

  // Result-side stall: short bursts, a few long holds, and stall-free stretches
  initial begin : result_backpressure
    int unsigned run;
    logic        level;
    out_stall = 1'b0;
    forever begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin level = 1'b0; run = $urandom_range(1, 20);   end
        4, 5, 6, 7: begin level = 1'b1; run = $urandom_range(1, 3);    end
        8:          begin level = 1'b1; run = $urandom_range(10, 40);  end
        default:    begin level = 1'b0; run = $urandom_range(50, 200); end
      endcase
      repeat (run) begin
        @(negedge clk);
        out_stall <= level;
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("servo_status_packet_receiver_tb: done, errors");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(19);
    if (quiet || r < 10) return 0;
    if (r < 17) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // Present one item after a random gap and hold it until accepted
  task automatic send_item(input cmd_t cmd, input logic [7:0] b, input bit typed,
                           input result_t rep);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_data_byte <= b;
    row_typed    <= typed;
    row_report   <= rep;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Send a byte, sometimes preceded by a tick
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < tick_pct) send_item(CMD_TICK, 8'($urandom), 1'b0, '0);
    send_item(CMD_BYTE, b, 1'b0, '0);
  endtask

  // Hold the sender until every expected report is in, then let the pipe settle
  task automatic settle_reports();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    settle_reports();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_writes++;
  endtask

  // Random frame, well-formed or with a bad length or bad sum, optional junk in front, sometimes cut short
  task automatic send_random_frame();
    logic [7:0]  id;
    logic [7:0]  len;
    logic [7:0]  err;
    logic [7:0]  sum;
    logic [7:0]  b;
    logic [7:0]  frame [$];
    int unsigned pre;
    int unsigned cut;
    id  = 8'($urandom);
    err = 8'($urandom);
    case ($urandom_range(19))
      0:          len = 8'($urandom_range(0, 1));
      1:          len = 8'd13;
      2:          len = 8'($urandom_range(14, 255));
      3, 4, 5:    len = 8'd12;
      default:    len = 8'($urandom_range(2, 12));
    endcase
    frame = '{HEADER_BYTE, HEADER_BYTE, id, len, err};
    sum   = id + len + err;
    if (len >= MIN_LEN && len <= FRAME_BYTES_DEF - HEAD_LEN) begin
      for (int i = 0; i < len - MIN_LEN; i++) begin
        b = 8'($urandom);
        frame.push_back(b);
        sum += b;
      end
    end
    frame.push_back(($urandom_range(4) == 0) ? 8'($urandom) : ~sum);
    send_item(CMD_START, 8'($urandom), 1'b0, '0);
    pre = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (pre) send_byte(8'($urandom));
    cut = ($urandom_range(9) == 0) ? $urandom_range(0, frame.size() - 1) : frame.size();
    for (int i = 0; i < cut; i++) send_byte(frame[i]);
  endtask

  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 6);
    repeat (n) send_item(cmd_t'($urandom_range(3)), 8'($urandom), 1'b0, '0);
  endtask

  initial begin : stimulus
    result_t     rep;
    int unsigned phase_end;
    logic [15:0] phase_timeout [PHASES];
    bit          phase_quiet;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_command   = CMD_NONE;
    in_data_byte = '0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    row_typed    = 1'b0;
    row_report   = '0;
    quiet        = 1'b0;
    tick_pct     = 0;

    directed_rows = '{
      '{ROW_ITEM, CMD_BYTE,  16'h55, 1'b0, ST_OK,      8'h00},  // idle: ignored
      '{ROW_ITEM, CMD_TICK,  16'h00, 1'b0, ST_OK,      8'h00},
      '{ROW_ITEM, CMD_NONE,  16'hA5, 1'b0, ST_OK,      8'h00},
      '{ROW_ITEM, CMD_START, 16'h00, 1'b0, ST_OK,      8'h00},
      '{ROW_ITEM, CMD_BYTE,  16'h12, 1'b0, ST_OK,      8'h00},  // junk: slide
      '{ROW_ITEM, CMD_BYTE,  16'hFF, 1'b0, ST_OK,      8'h00},
      '{ROW_ITEM, CMD_BYTE,  16'hFF, 1'b0, ST_OK,      8'h00},
      '{ROW_ITEM, CMD_BYTE,  16'hFE, 1'b0, ST_OK,      8'h00},
      '{ROW_ITEM, CMD_BYTE,  16'h02, 1'b0, ST_OK,      8'h00},  // shortest length
      '{ROW_ITEM, CMD_BYTE,  16'h00, 1'b0, ST_OK,      8'h00},
      '{ROW_ITEM, CMD_BYTE,  16'hFF, 1'b1, ST_OK,      8'hFE},
      '{ROW_ITEM, CMD_START, 16'h00, 1'b0, ST_OK,      8'h00},
      '{ROW_ITEM, CMD_BYTE,  16'hFF, 1'b0, ST_OK,      8'h00},
      '{ROW_ITEM, CMD_START, 16'h00, 1'b0, ST_OK,      8'h00},  // restart while armed
      '{ROW_ITEM, CMD_BYTE,  16'hFF, 1'b0, ST_OK,      8'h00},
      '{ROW_ITEM, CMD_BYTE,  16'hFF, 1'b0, ST_OK,      8'h00},
      '{ROW_ITEM, CMD_BYTE,  16'h00, 1'b0, ST_OK,      8'h00},
      '{ROW_ITEM, CMD_BYTE,  16'h01, 1'b1, ST_BAD_LEN, 8'h00},  // length too short
      '{ROW_ITEM, CMD_START, 16'h00, 1'b0, ST_OK,      8'h00},
      '{ROW_ITEM, CMD_BYTE,  16'hFF, 1'b0, ST_OK,      8'h00},
      '{ROW_ITEM, CMD_BYTE,  16'hFF, 1'b0, ST_OK,      8'h00},
      '{ROW_ITEM, CMD_BYTE,  16'hFF, 1'b0, ST_OK,      8'h00},
      '{ROW_ITEM, CMD_BYTE,  16'hFF, 1'b1, ST_BAD_LEN, 8'hFF},  // length far too long
      '{ROW_CFG,  CMD_NONE,  16'h01, 1'b0, ST_OK,      8'h00},
      '{ROW_ITEM, CMD_START, 16'h00, 1'b0, ST_OK,      8'h00},
      '{ROW_ITEM, CMD_TICK,  16'h00, 1'b1, ST_TIMEOUT, 8'h00}   // shortest timeout
    };

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_timeout(directed_rows[i].value);
      end else begin
        rep          = '0;
        rep.status   = directed_rows[i].st;
        rep.servo_id = directed_rows[i].id;
        send_item(directed_rows[i].cmd, directed_rows[i].value[7:0], directed_rows[i].typed, rep);
      end
    end

    // Random part: one timeout setting per phase, frames mixed with noise
    phase_timeout = '{16'd65535, 16'd1, 16'd12, 16'($urandom_range(2, 60)), 16'd40, TIMEOUT_RESET};
    foreach (phase_timeout[p]) begin
      write_timeout(phase_timeout[p]);
      phase_quiet = ($urandom_range(3) == 0);
      tick_pct    = $urandom_range(0, 15);
      phase_end   = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < phase_end) begin
        quiet = phase_quiet || ($urandom_range(9) == 0);
        if ($urandom_range(99) < 80) send_random_frame();
        else send_noise();
        if ($urandom_range(49) == 0) settle_reports();
      end
    end

    settle_reports();
    repeat (5) @(negedge clk);

    $display("covered %0d items, %0d timeout settings, %0d reports", items_sent, cfg_writes,
             reports_seen);
    $display("reports by status: ok %0d, bad sum %0d, timeout %0d, bad length %0d",
             status_seen[ST_OK], status_seen[ST_BAD_SUM], status_seen[ST_TIMEOUT],
             status_seen[ST_BAD_LEN]);
    if (mismatch_count == 0) begin
      $display("servo_status_packet_receiver_tb: done, clean");
    end else begin
      $display("servo_status_packet_receiver_tb: done, errors");
    end
    $finish;
  end

endmodule
